// ----- rtl/core/ddpi_pkg.sv -----
// Shared types and constants for the differential-drive PI speed controller.
package ddpi_pkg;

	// Field and register widths fixed by the interface
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int SPEED_W    = 16;
	localparam int CMD_OUT_W  = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Multiplier chunking of the wide operand
	localparam int CHUNK_W = 16;

	// Saturation points: correction to 2^40, percent term to 2^30, command to 100 %
	localparam int CORR_LOG = 40;
	localparam int PCT_LOG  = 30;
	localparam int CMD_PCT  = 100;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_ANG    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_ANG    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_ANG   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_LIN    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_LIN    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_LIN   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_ANG = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_LIN = 4'd7;

	// Register reset values
	localparam logic [GAIN_W-1:0]  RST_KP_ANG    = 16'd461;
	localparam logic [GAIN_W-1:0]  RST_KI_ANG    = 16'd90;
	localparam logic [LIMIT_W-1:0] RST_LIM_ANG   = 31'd8272;
	localparam logic [GAIN_W-1:0]  RST_KP_LIN    = 16'd0;
	localparam logic [GAIN_W-1:0]  RST_KI_LIN    = 16'd0;
	localparam logic [LIMIT_W-1:0] RST_LIM_LIN   = 31'd0;
	localparam logic [GAIN_W-1:0]  RST_SCALE_ANG = 16'd256;
	localparam logic [GAIN_W-1:0]  RST_SCALE_LIN = 16'd256;

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic clr;   // zero the accumulator
		logic en;    // add the current partial product
		logic top;   // current chunk is the signed top chunk
	} mac_ctl_t;

endpackage

// ----- rtl/core/differential_drive_pi_speed_control.sv -----
// Top level: two PI speed loops on one shared multiply-accumulate unit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-------------------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write in
//  in      | in_valid/in_ready, 4 speed fields         | control tick in
//  out     | out_valid/out_ready, right/left command   | motor commands out
//
// One request runs the angular loop and then the linear loop on the single
// 17x17 multiplier, with NC = ceil(max(SUM_WIDTH, 42) / 16) (3 at the defaults);
// the multiplier is used NC times for each of kp*err, ki*sum and scale*corr in
// each loop.
// in_ready is high only when the sequencer is idle; a finished result waits in
// the output register, and a new request is taken meanwhile.
// Reset clears the sequencer, both error sums and the registers to defaults.
// cfg_ready is always high; writes are expected only while idle.
module differential_drive_pi_speed_control #(
	parameter int SUM_WIDTH     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ddpi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ddpi_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ddpi_pkg::SPEED_W-1:0]   angular_target,
	input  logic signed [ddpi_pkg::SPEED_W-1:0]   angular_measured,
	input  logic signed [ddpi_pkg::SPEED_W-1:0]   linear_target,
	input  logic signed [ddpi_pkg::SPEED_W-1:0]   linear_measured,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ddpi_pkg::CMD_OUT_W-1:0] right_command,
	output logic signed [ddpi_pkg::CMD_OUT_W-1:0] left_command
);

	localparam int CORR_W = ddpi_pkg::CORR_LOG + 2;
	localparam int WW     = (SUM_WIDTH > CORR_W) ? SUM_WIDTH : CORR_W;
	localparam int NC     = (WW + ddpi_pkg::CHUNK_W - 1) / ddpi_pkg::CHUNK_W;
	localparam int OPW    = NC * ddpi_pkg::CHUNK_W;
	localparam int ACC_W  = OPW + ddpi_pkg::CHUNK_W + 2;
	localparam int CW     = $clog2(NC);
	localparam int XW     = ((SUM_WIDTH > ddpi_pkg::LIMIT_W) ? SUM_WIDTH
	                         : ddpi_pkg::LIMIT_W) + 2;
	localparam int ERR_W  = ddpi_pkg::SPEED_W + 1;
	localparam int PCT_W  = ddpi_pkg::PCT_LOG + 2;
	localparam int CMD_W  = PCT_W + 1;

	localparam logic signed [XW-1:0]    SUM_MAX  = (XW'(1) << (SUM_WIDTH - 1)) - XW'(1);
	localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'(1) << ddpi_pkg::CORR_LOG;
	localparam logic signed [ACC_W-1:0] PCT_MAX  = ACC_W'(1) << ddpi_pkg::PCT_LOG;
	localparam logic signed [CMD_W-1:0] CMD_MAX  =
		CMD_W'(ddpi_pkg::CMD_PCT) << FRACTION_BITS;
	localparam logic [CW-1:0]           IDX_LAST = CW'(NC - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SUM, ST_MKP, ST_MKI, ST_CORR, ST_MSC, ST_PCT, ST_CMB
	} state_t;

	state_t state_q;
	logic   lp_q;                 // 0: angular loop, 1: linear loop
	logic [CW-1:0] idx_q;
	logic   out_valid_q;

	// Configuration registers
	logic [ddpi_pkg::GAIN_W-1:0]  kp_ang_q, ki_ang_q, kp_lin_q, ki_lin_q;
	logic [ddpi_pkg::GAIN_W-1:0]  scale_ang_q, scale_lin_q;
	logic [ddpi_pkg::LIMIT_W-1:0] lim_ang_q, lim_lin_q;

	// Loop state
	logic signed [SUM_WIDTH-1:0] ang_sum_q, lin_sum_q;

	// Datapath registers
	logic signed [ddpi_pkg::SPEED_W-1:0] ang_tgt_q, ang_meas_q, lin_tgt_q, lin_meas_q;
	logic [OPW-1:0]                      op_q;
	logic signed [PCT_W-1:0]             ang_pct_q, lin_pct_q;
	logic signed [ddpi_pkg::CMD_OUT_W-1:0] right_q, left_q;

	// Loop-selected operands
	logic signed [ddpi_pkg::SPEED_W-1:0] tgt_sel, meas_sel;
	logic [ddpi_pkg::GAIN_W-1:0]         kp_sel, ki_sel, scale_sel, gain_sel;
	logic [ddpi_pkg::LIMIT_W-1:0]        lim_sel;
	logic signed [SUM_WIDTH-1:0]         sum_sel;

	logic signed [ERR_W-1:0]  err_c;
	logic signed [XW-1:0]     sum_x, err_x, raw_x, lim_x, lim_c, clamp_x;
	logic signed [SUM_WIDTH-1:0] sum_new;
	logic signed [ACC_W-1:0]  acc, acc_sh, corr_c, pct_c;
	logic signed [CMD_W-1:0]  pct_a, pct_l, right_c, left_c, rsum, ldif;
	logic                     chunk_last;
	logic                     out_load;
	ddpi_pkg::mac_ctl_t       mac_ctl;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign right_command = right_q;
	assign left_command  = left_q;

	assign chunk_last = (idx_q == IDX_LAST);
	assign out_load   = (state_q == ST_CMB) && (!out_valid_q || out_ready);

	// Operand selection by loop
	always_comb begin
		tgt_sel   = lp_q ? lin_tgt_q   : ang_tgt_q;
		meas_sel  = lp_q ? lin_meas_q  : ang_meas_q;
		kp_sel    = lp_q ? kp_lin_q    : kp_ang_q;
		ki_sel    = lp_q ? ki_lin_q    : ki_ang_q;
		scale_sel = lp_q ? scale_lin_q : scale_ang_q;
		lim_sel   = lp_q ? lim_lin_q   : lim_ang_q;
		sum_sel   = lp_q ? lin_sum_q   : ang_sum_q;
	end

	// Error and clamped error sum
	always_comb begin
		err_c = {tgt_sel[ddpi_pkg::SPEED_W-1], tgt_sel}
		      - {meas_sel[ddpi_pkg::SPEED_W-1], meas_sel};
		sum_x = {{(XW-SUM_WIDTH){sum_sel[SUM_WIDTH-1]}}, sum_sel};
		err_x = {{(XW-ERR_W){err_c[ERR_W-1]}}, err_c};
		raw_x = sum_x + err_x;
		lim_x = {{(XW-ddpi_pkg::LIMIT_W){1'b0}}, lim_sel};
		lim_c = (lim_x > SUM_MAX) ? SUM_MAX : lim_x;
		priority if (raw_x > lim_c) begin
			clamp_x = lim_c;
		end else if (raw_x < -lim_c) begin
			clamp_x = -lim_c;
		end else begin
			clamp_x = raw_x;
		end
		sum_new = clamp_x[SUM_WIDTH-1:0];
	end

	// Floor shift of the accumulator and saturation of correction and percent
	always_comb begin
		acc_sh = acc >>> FRACTION_BITS;
		priority if (acc_sh > CORR_MAX) begin
			corr_c = CORR_MAX;
		end else if (acc_sh < -CORR_MAX) begin
			corr_c = -CORR_MAX;
		end else begin
			corr_c = acc_sh;
		end
		priority if (acc_sh > PCT_MAX) begin
			pct_c = PCT_MAX;
		end else if (acc_sh < -PCT_MAX) begin
			pct_c = -PCT_MAX;
		end else begin
			pct_c = acc_sh;
		end
	end

	// Wheel mix and command saturation
	always_comb begin
		pct_a = {ang_pct_q[PCT_W-1], ang_pct_q};
		pct_l = {lin_pct_q[PCT_W-1], lin_pct_q};
		rsum  = pct_l + pct_a;
		ldif  = pct_l - pct_a;
		priority if (rsum > CMD_MAX) begin
			right_c = CMD_MAX;
		end else if (rsum < -CMD_MAX) begin
			right_c = -CMD_MAX;
		end else begin
			right_c = rsum;
		end
		priority if (ldif > CMD_MAX) begin
			left_c = CMD_MAX;
		end else if (ldif < -CMD_MAX) begin
			left_c = -CMD_MAX;
		end else begin
			left_c = ldif;
		end
	end

	// Multiplier control and gain select
	always_comb begin
		mac_ctl.clr = (state_q == ST_SUM) || (state_q == ST_CORR);
		mac_ctl.en  = (state_q == ST_MKP) || (state_q == ST_MKI) || (state_q == ST_MSC);
		mac_ctl.top = chunk_last;
		unique case (state_q)
			ST_MKP:  gain_sel = kp_sel;
			ST_MKI:  gain_sel = ki_sel;
			ST_MSC:  gain_sel = scale_sel;
			default: gain_sel = '0;
		endcase
	end

	ddpi_mac #(
		.ACC_W (ACC_W),
		.CW    (CW)
	) u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.gain  (gain_sel),
		.chunk (op_q[ddpi_pkg::CHUNK_W-1:0]),
		.idx   (idx_q),
		.acc   (acc)
	);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lp_q        <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lp_q    <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					idx_q   <= '0;
					state_q <= ST_MKP;
				end
				ST_MKP: begin
					idx_q <= idx_q + CW'(1);
					if (chunk_last) begin
						idx_q   <= '0;
						state_q <= ST_MKI;
					end
				end
				ST_MKI: begin
					idx_q <= idx_q + CW'(1);
					if (chunk_last) begin
						idx_q   <= '0;
						state_q <= ST_CORR;
					end
				end
				ST_CORR: begin
					idx_q   <= '0;
					state_q <= ST_MSC;
				end
				ST_MSC: begin
					idx_q <= idx_q + CW'(1);
					if (chunk_last) begin
						idx_q   <= '0;
						state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					if (!lp_q) begin
						lp_q    <= 1'b1;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_CMB;
					end
				end
				ST_CMB: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Error sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_sum_q <= '0;
			lin_sum_q <= '0;
		end else if (state_q == ST_SUM) begin
			if (lp_q) begin
				lin_sum_q <= sum_new;
			end else begin
				ang_sum_q <= sum_new;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_ang_q    <= ddpi_pkg::RST_KP_ANG;
			ki_ang_q    <= ddpi_pkg::RST_KI_ANG;
			lim_ang_q   <= ddpi_pkg::RST_LIM_ANG;
			kp_lin_q    <= ddpi_pkg::RST_KP_LIN;
			ki_lin_q    <= ddpi_pkg::RST_KI_LIN;
			lim_lin_q   <= ddpi_pkg::RST_LIM_LIN;
			scale_ang_q <= ddpi_pkg::RST_SCALE_ANG;
			scale_lin_q <= ddpi_pkg::RST_SCALE_LIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ddpi_pkg::REG_KP_ANG:    kp_ang_q    <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				ddpi_pkg::REG_KI_ANG:    ki_ang_q    <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				ddpi_pkg::REG_LIM_ANG:   lim_ang_q   <= cfg_data[ddpi_pkg::LIMIT_W-1:0];
				ddpi_pkg::REG_KP_LIN:    kp_lin_q    <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				ddpi_pkg::REG_KI_LIN:    ki_lin_q    <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				ddpi_pkg::REG_LIM_LIN:   lim_lin_q   <= cfg_data[ddpi_pkg::LIMIT_W-1:0];
				ddpi_pkg::REG_SCALE_ANG: scale_ang_q <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				ddpi_pkg::REG_SCALE_LIN: scale_lin_q <= cfg_data[ddpi_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath: request capture, operand shifter, percent terms, output register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ang_tgt_q  <= angular_target;
			ang_meas_q <= angular_measured;
			lin_tgt_q  <= linear_target;
			lin_meas_q <= linear_measured;
		end
		unique case (state_q)
			ST_SUM: begin
				op_q <= {{(OPW-ERR_W){err_c[ERR_W-1]}}, err_c};
			end
			ST_MKP: begin
				if (chunk_last) begin
					op_q <= {{(OPW-SUM_WIDTH){sum_sel[SUM_WIDTH-1]}}, sum_sel};
				end else begin
					op_q <= op_q >> ddpi_pkg::CHUNK_W;
				end
			end
			ST_CORR: begin
				op_q <= corr_c[OPW-1:0];
			end
			ST_MKI, ST_MSC: begin
				op_q <= op_q >> ddpi_pkg::CHUNK_W;
			end
			ST_PCT: begin
				if (lp_q) begin
					lin_pct_q <= pct_c[PCT_W-1:0];
				end else begin
					ang_pct_q <= pct_c[PCT_W-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			right_q <= right_c[ddpi_pkg::CMD_OUT_W-1:0];
			left_q  <= left_c[ddpi_pkg::CMD_OUT_W-1:0];
		end
	end

endmodule

// ----- rtl/core/ddpi_mac.sv -----
// Shared chunked multiply-accumulate unit: acc += gain * chunk << (16 * idx).
module ddpi_mac #(
	parameter int ACC_W = 66,
	parameter int CW    = 2
) (
	input  logic                              clk,
	input  ddpi_pkg::mac_ctl_t                ctl,
	input  logic [ddpi_pkg::GAIN_W-1:0]       gain,
	input  logic [ddpi_pkg::CHUNK_W-1:0]      chunk,
	input  logic [CW-1:0]                     idx,
	output logic signed [ACC_W-1:0]           acc
);

	localparam int PROD_W = ddpi_pkg::GAIN_W + ddpi_pkg::CHUNK_W + 2;

	logic signed [ddpi_pkg::GAIN_W:0]  g;
	logic signed [ddpi_pkg::CHUNK_W:0] c;
	logic signed [PROD_W-1:0]          prod;
	logic signed [ACC_W-1:0]           pext;
	logic signed [ACC_W-1:0]           term;
	logic signed [ACC_W-1:0]           acc_q;

	// Unsigned gain times one chunk; lower chunks unsigned, top chunk signed
	always_comb begin
		g    = {1'b0, gain};
		c    = {ctl.top & chunk[ddpi_pkg::CHUNK_W-1], chunk};
		prod = g * c;
		pext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		term = pext << (ddpi_pkg::CHUNK_W * int'(idx));
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= acc_q + term;
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/core/ddpi_chk.sv -----
// Port-level checker for the PI speed controller, bound to the top level.
module ddpi_chk #(
	parameter int FRACTION_BITS = 8
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic [ddpi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input logic [ddpi_pkg::CFG_DATA_W-1:0]       cfg_data,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic signed [ddpi_pkg::SPEED_W-1:0]   angular_target,
	input logic signed [ddpi_pkg::SPEED_W-1:0]   angular_measured,
	input logic signed [ddpi_pkg::SPEED_W-1:0]   linear_target,
	input logic signed [ddpi_pkg::SPEED_W-1:0]   linear_measured,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [ddpi_pkg::CMD_OUT_W-1:0] right_command,
	input logic signed [ddpi_pkg::CMD_OUT_W-1:0] left_command
);

	localparam int CMD_CHK_W = ddpi_pkg::CMD_OUT_W + FRACTION_BITS + 8;
	localparam logic signed [CMD_CHK_W-1:0] CMD_MAX =
		CMD_CHK_W'(ddpi_pkg::CMD_PCT) << FRACTION_BITS;

	logic signed [CMD_CHK_W-1:0] right_x, left_x;

	assign right_x = CMD_CHK_W'(right_command);
	assign left_x  = CMD_CHK_W'(left_command);

	// Busy after a request: no second request in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the sequencer was busy");

	// A result never appears right after a request is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a request");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(right_command)
			&& $stable(left_command))
		else $error("stalled result changed or dropped");

	// Commands stay within plus or minus 100 percent when the 16-bit port can hold it
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (FRACTION_BITS <= 8) |-> (right_x <= CMD_MAX) && (right_x >= -CMD_MAX)
			&& (left_x <= CMD_MAX) && (left_x >= -CMD_MAX))
		else $error("motor command outside the saturation range");

endmodule

bind differential_drive_pi_speed_control ddpi_chk #(
	.FRACTION_BITS (FRACTION_BITS)
) u_ddpi_chk (.*);
